/* sv/stm_pkg.sv */
`default_nettype none

package stm_pkg;

    localparam int ROW_W   = 16;
    localparam int COL_W   = 16;
    localparam int VALUE_W = 16;
    localparam int OUT_VALUE_W = 17;

    // Item kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2
    } mode_t;

    // Register byte addresses on the configuration port
    localparam logic [2:0] REG_SUBTRACT_ADDR = 3'd0;

    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } triplet_t;

    localparam int TRIPLET_W = $bits(triplet_t);

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic step;
        logic emit_empty;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_space;
        logic lists_empty;
        logic last_step;
    } stat_t;

endpackage

`default_nettype wire

/* sv/sparse_triplet_merge_add_sub.sv */
// Load beats (list A or B) are accepted one every cycle while idle. A run beat starts
// the merge; results leave the output register one per cycle unless m_tready holds
// them, count_a + count_b at most, or one empty-result beat if both lists are empty;
// the loop is set by the registered read of the list RAMs, addressed at the next head.
// Reset (rst_n, asynchronous) clears list counts, the subtract bit and the output
// valid; list RAM contents stay undefined until loaded.
`default_nettype none

module sparse_triplet_merge_add_sub #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side: load and run beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row [15:0], col [31:16], value [47:32]
    input  wire logic [1:0]  s_tuser,   // mode [1:0]
    // master side: merged result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_row [15:0], out_col [31:16],
                                        // out_value [48:32], zero [55:49]
    output logic             m_tlast,
    output logic [0:0]       m_tuser,   // empty_result [0]
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import stm_pkg::*;

    mode_t    mode;
    triplet_t in_item;
    cmd_t     cmd;
    stat_t    stat;
    logic     subtract_reg;

    logic [ROW_W-1:0]              out_row;
    logic [COL_W-1:0]              out_col;
    logic signed [OUT_VALUE_W-1:0] out_value;
    logic                          out_last;
    logic                          out_empty;

    // Unpack the slave beat
    assign mode          = mode_t'(s_tuser);
    assign in_item.row   = s_tdata[15:0];
    assign in_item.col   = s_tdata[31:16];
    assign in_item.value = s_tdata[47:32];

    // Configuration: one register, written on the access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subtract_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_SUBTRACT_ADDR))
        begin
            subtract_reg <= pwdata[0];
        end
    end

    // read back the subtract bit; other addresses read zero
    assign prdata = (paddr == REG_SUBTRACT_ADDR) ? {31'b0, subtract_reg} : 32'b0;

    // Controller: accepts beats while idle, walks the merge one result per cycle while the output register has space
    stm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (mode),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: list RAMs, counts, head compare, add/sub and output register
    stm_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .subtract  (subtract_reg),
        .in_item   (in_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

    // Pack the master beat
    assign m_tdata = {7'b0, out_value, out_col, out_row};
    assign m_tlast = out_last;
    assign m_tuser = out_empty;

endmodule

`default_nettype wire

/* sv/stm_ram.sv */
`default_nettype none

module stm_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/stm_ctrl.sv */
`default_nettype none

module stm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire stm_pkg::mode_t  mode,
    output logic                 s_tready,
    input  wire stm_pkg::stat_t  stat,
    output stm_pkg::cmd_t        cmd
);

    import stm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (mode)
                        MODE_LOAD_A: cmd.load_a = 1'b1;
                        MODE_LOAD_B: cmd.load_b = 1'b1;
                        MODE_RUN:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE:
            begin
                // hold while the output register is occupied
                if (stat.out_space)
                begin
                    if (stat.lists_empty)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                        if (stat.last_step)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_step_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.emit_empty) |-> stat.out_space)
        else $error("merge step issued without output space");

    a_start_enters_merge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_MERGE))
        else $error("run beat did not enter merge");

endmodule

`default_nettype wire

/* sv/stm_dpath.sv */
`default_nettype none

module stm_dpath #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire stm_pkg::cmd_t                       cmd,
    output stm_pkg::stat_t                           stat,
    input  wire logic                                subtract,
    input  wire stm_pkg::triplet_t                   in_item,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [stm_pkg::ROW_W-1:0]                out_row,
    output logic [stm_pkg::COL_W-1:0]                out_col,
    output logic signed [stm_pkg::OUT_VALUE_W-1:0]   out_value,
    output logic                                     out_last,
    output logic                                     out_empty
);

    import stm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int RAM_DEPTH = 1 << AW;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] i_step, j_step;

    logic [TRIPLET_W-1:0] a_rdata, b_rdata;
    triplet_t a_head, b_head;
    logic a_full, b_full;
    logic we_a, we_b;
    logic a_has, b_has;
    logic [ROW_W+COL_W-1:0] key_a, key_b;
    logic take_a, take_b, take_both;
    logic signed [OUT_VALUE_W-1:0] a_ext, b_ext, b_term, merged;

    logic                          out_valid_reg;
    logic [ROW_W-1:0]              out_row_reg;
    logic [COL_W-1:0]              out_col_reg;
    logic signed [OUT_VALUE_W-1:0] out_value_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;

    assign a_full = (cnt_a_reg == CW'(LIST_DEPTH));
    assign b_full = (cnt_b_reg == CW'(LIST_DEPTH));
    assign we_a   = cmd.load_a && !a_full;
    assign we_b   = cmd.load_b && !b_full;

    assign cnt_a_next = we_a ? cnt_a_reg + CW'(1) : cnt_a_reg;
    assign cnt_b_next = we_b ? cnt_b_reg + CW'(1) : cnt_b_reg;

    stm_ram #(
        .WIDTH (TRIPLET_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (in_item),
        .raddr (i_next[AW-1:0]),
        .rdata (a_rdata)
    );

    stm_ram #(
        .WIDTH (TRIPLET_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (in_item),
        .raddr (j_next[AW-1:0]),
        .rdata (b_rdata)
    );

    assign a_head = triplet_t'(a_rdata);
    assign b_head = triplet_t'(b_rdata);

    // head compare by (row, col)
    assign a_has = (i_reg < cnt_a_reg);
    assign b_has = (j_reg < cnt_b_reg);
    assign key_a = {a_head.row, a_head.col};
    assign key_b = {b_head.row, b_head.col};

    assign take_a    = a_has && (!b_has || (key_a < key_b));
    assign take_b    = !take_a && b_has && (!a_has || (key_a > key_b));
    assign take_both = !take_a && !take_b;

    assign i_step = (take_a || take_both) ? i_reg + CW'(1) : i_reg;
    assign j_step = (take_b || take_both) ? j_reg + CW'(1) : j_reg;

    // read address follows the next head so the RAM data is current
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.start)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.step)
        begin
            i_next = i_step;
            j_next = j_step;
        end
    end

    assign a_ext  = OUT_VALUE_W'(a_head.value);
    assign b_ext  = OUT_VALUE_W'(b_head.value);
    assign b_term = subtract ? -b_ext : b_ext;

    always_comb
    begin
        if (take_a)
        begin
            merged = a_ext;
        end
        else if (take_b)
        begin
            merged = b_term;
        end
        else
        begin
            merged = a_ext + b_term;
        end
    end

    assign stat.out_space   = !out_valid_reg || m_tready;
    assign stat.lists_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign stat.last_step   = (i_step == cnt_a_reg) && (j_step == cnt_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cmd.step || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_empty)
        begin
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b0;
            out_empty_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            out_row_reg   <= take_b ? b_head.row : a_head.row;
            out_col_reg   <= take_b ? b_head.col : a_head.col;
            out_value_reg <= merged;
            out_last_reg  <= stat.last_step;
            out_empty_reg <= 1'b0;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

    a_step_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (a_has || b_has))
        else $error("merge step with both lists exhausted");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (i_reg <= cnt_a_reg) || (j_reg <= cnt_b_reg) || !cmd.step)
        else $error("merge index passed its list count");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.last_step) |=> (m_tvalid && out_last && !out_empty))
        else $error("final merge beat not marked last");

endmodule

`default_nettype wire
